### hw/rtl/replacement_selection_runs_defines.svh
// assertion macros for the run generator
`ifndef REPLACEMENT_SELECTION_RUNS_DEFINES_SVH
`define REPLACEMENT_SELECTION_RUNS_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define RSR_ASSERT_IMP(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");
// next-cycle implication outside reset
`define RSR_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");
`endif

### hw/rtl/rsr_pkg.sv
// ----------------------------------------------------------------------------
// rsr_pkg
// shared types and constants of the replacement selection run generator
// ----------------------------------------------------------------------------
package rsr_pkg;
   localparam int HeapCap = 1024;
   localparam int AddrW = $clog2(HeapCap);
   localparam int CntW = AddrW + 1;
   localparam int KeyW = 32;
   localparam int RunW = 16;

   localparam logic CmdPush = 1'b0;
   localparam logic CmdDrain = 1'b1;

   typedef logic [AddrW-1:0] addr_type;
   typedef logic [CntW-1:0] cnt_type;
   typedef logic signed [KeyW-1:0] key_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_UP_RD,
      ST_UP_CMP,
      ST_DN_RD,
      ST_DN_L,
      ST_DN_R,
      ST_DN_SWAP,
      ST_MV_RD,
      ST_MV_WR,
      ST_BUILD,
      ST_DONE,
      ST_OUT
   } state_type;
endpackage

### hw/rtl/replacement_selection_runs.sv
// ----------------------------------------------------------------------------
// replacement_selection_runs
// run generation for an external sort by replacement selection on a min-heap
// ----------------------------------------------------------------------------
// usage:
//   req channel: cmd (0 push key, 1 drain one key) and key; one item is taken
//   when req_valid is high and req_stall low. the block takes no new item
//   until the current item has finished, so req_stall stays high meanwhile
//   rsp channel: out_key, run_index, run_first, empty_res; at most one item
//   per request. pushes while the store fills produce no rsp item
//   steps: a push while filling sifts up or is parked; an emitting push
//   or a drain sifts the root down; a run switch moves the parked keys and
//   heapifies them (sift per inner node)
//   throughput: one item at a time, the next is taken once the block is idle
//   all work goes through the one read and one write port of the key store
//   reset: counters, run number and the started flag clear; the key store is not
//   cleared, no entry is read before it is written
//   a stalled rsp item holds its payload; the next request waits for it
// ----------------------------------------------------------------------------
module replacement_selection_runs (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_cmd,
   input  logic signed [31:0]   req_key,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [31:0]   rsp_out_key,
   output logic [15:0]          rsp_run_index,
   output logic                 rsp_run_first,
   output logic                 rsp_empty_res
);
   import rsr_pkg::*;

   state_type state_ff, state_in;

   // architectural state
   cnt_type live_ff, live_in;
   cnt_type parked_ff, parked_in;
   logic [RunW-1:0] run_ff, run_in;
   logic started_ff, started_in;

   // working registers
   logic cmd_ff, cmd_in;
   key_type key_ff, key_in;       // pushed key
   key_type cur_ff, cur_in;       // value at pos
   key_type best_ff, best_in;     // smallest seen during a sift step
   cnt_type pos_ff, pos_in;
   cnt_type bpos_ff, bpos_in;     // index of smallest
   cnt_type size_ff, size_in;     // sift bound
   cnt_type mv_ff, mv_in;         // move / build counter
   logic emit_ff, emit_in;        // request gives a rsp item
   logic run_sw_ff, run_sw_in;    // run switch pending after sift
   logic reload_ff, reload_in;    // sift value comes from the store read

   // rsp holding register
   key_type ok_ff, ok_in;
   logic [RunW-1:0] ri_ff, ri_in;
   logic rf_ff, rf_in, er_ff, er_in;

   // store port
   logic wr_en;
   addr_type wr_addr, rd_addr;
   key_type wr_data, rd_data;

   rsr_ram u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_out_key = ok_ff;
   assign rsp_run_index = ri_ff;
   assign rsp_run_first = rf_ff;
   assign rsp_empty_res = er_ff;

   // child indices of pos
   cnt_type lchild, rchild;
   assign lchild = cnt_type'({pos_ff, 1'b0} + 1);
   assign rchild = cnt_type'({pos_ff, 1'b0} + 2);

   cnt_type total;
   assign total = live_ff + parked_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         live_ff <= '0;
         parked_ff <= '0;
         run_ff <= '0;
         started_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         live_ff <= live_in;
         parked_ff <= parked_in;
         run_ff <= run_in;
         started_ff <= started_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      key_ff <= key_in;
      cur_ff <= cur_in;
      best_ff <= best_in;
      pos_ff <= pos_in;
      bpos_ff <= bpos_in;
      size_ff <= size_in;
      mv_ff <= mv_in;
      emit_ff <= emit_in;
      run_sw_ff <= run_sw_in;
      reload_ff <= reload_in;
      ok_ff <= ok_in;
      ri_ff <= ri_in;
      rf_ff <= rf_in;
      er_ff <= er_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            // root value ready in rd_data
            if (cmd_ff == CmdPush && total < cnt_type'(HeapCap)) begin
               if (started_ff && live_ff != '0 && key_ff < rd_data) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_UP_RD;
               end
            end else if (cmd_ff == CmdDrain && live_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_DN_RD;
            end
         end
         ST_UP_RD: state_in = (pos_ff == '0) ? ST_DONE : ST_UP_CMP;
         ST_UP_CMP: state_in = (cur_ff < rd_data) ? ST_UP_RD : ST_DONE;
         ST_DN_RD: state_in = (lchild < size_ff) ? ST_DN_L : ST_DN_SWAP;
         ST_DN_L: state_in = ST_DN_R;
         ST_DN_R: state_in = ST_DN_SWAP;
         ST_DN_SWAP: begin
            if (bpos_ff != pos_ff) begin
               state_in = ST_DN_RD;
            end else if (run_sw_ff) begin
               state_in = ST_MV_RD;
            end else if (mv_ff != '0) begin
               state_in = ST_BUILD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_MV_RD: state_in = ST_MV_WR;
         ST_MV_WR: state_in = (mv_ff == parked_ff - cnt_type'(1)) ? ST_BUILD : ST_MV_RD;
         ST_BUILD: state_in = ST_DN_RD;
         ST_DONE: state_in = emit_ff ? ST_OUT : ST_IDLE;
         ST_OUT: state_in = rsp_stall ? ST_OUT : ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and store port
   always_comb begin
      live_in = live_ff;
      parked_in = parked_ff;
      run_in = run_ff;
      started_in = started_ff;
      cmd_in = cmd_ff;
      key_in = key_ff;
      cur_in = cur_ff;
      best_in = best_ff;
      pos_in = pos_ff;
      bpos_in = bpos_ff;
      size_in = size_ff;
      mv_in = mv_ff;
      emit_in = emit_ff;
      run_sw_in = run_sw_ff;
      reload_in = reload_ff;
      ok_in = ok_ff;
      ri_in = ri_ff;
      rf_in = rf_ff;
      er_in = er_ff;
      wr_en = 1'b0;
      wr_addr = '0;
      wr_data = key_ff;
      rd_addr = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd_in = req_cmd;
            key_in = req_key;
            emit_in = 1'b0;
            run_sw_in = 1'b0;
            reload_in = 1'b0;
            mv_in = '0;
            rd_addr = '0;
         end
         ST_DISPATCH: begin
            if (cmd_ff == CmdPush && total < cnt_type'(HeapCap)) begin
               if (started_ff && live_ff != '0 && key_ff < rd_data) begin
                  // park below the live minimum
                  wr_en = 1'b1;
                  wr_addr = addr_type'(cnt_type'(HeapCap) - parked_ff - cnt_type'(1));
                  parked_in = parked_ff + cnt_type'(1);
               end else begin
                  wr_en = 1'b1;
                  wr_addr = addr_type'(live_ff);
                  cur_in = key_ff;
                  pos_in = live_ff;
                  live_in = live_ff + cnt_type'(1);
                  rd_addr = addr_type'((live_ff - cnt_type'(1)) >> 1);
               end
            end else if (cmd_ff == CmdDrain && live_ff == '0) begin
               emit_in = 1'b1;
               ok_in = '0;
               ri_in = '0;
               rf_in = 1'b0;
               er_in = 1'b1;
            end else begin
               emit_in = 1'b1;
               ok_in = rd_data;
               ri_in = run_ff;
               rf_in = !started_ff;
               er_in = 1'b0;
               started_in = 1'b1;
               pos_in = '0;
               size_in = live_ff;
               if (cmd_ff == CmdPush && key_ff >= rd_data) begin
                  wr_en = 1'b1;
                  wr_addr = '0;
                  cur_in = key_ff;
               end else begin
                  // last live key to root; read it via DN_RD path
                  wr_en = (cmd_ff == CmdPush);
                  wr_addr = addr_type'(cnt_type'(HeapCap) - parked_ff - cnt_type'(1));
                  live_in = live_ff - cnt_type'(1);
                  size_in = live_ff - cnt_type'(1);
                  if (cmd_ff == CmdPush) begin
                     parked_in = parked_ff + cnt_type'(1);
                     run_sw_in = (live_ff == cnt_type'(1));
                  end else begin
                     run_sw_in = (live_ff == cnt_type'(1)) && (parked_ff != '0);
                  end
                  if (live_ff == cnt_type'(1) && (cmd_ff == CmdDrain) && parked_ff == '0) begin
                     run_in = run_ff + RunW'(1);
                     started_in = 1'b0;
                  end
                  rd_addr = addr_type'(live_ff - cnt_type'(1));
                  reload_in = 1'b1;
               end
            end
         end
         ST_UP_RD: begin
            // key reached the root
            if (pos_ff == '0) begin
               wr_en = 1'b1;
               wr_addr = '0;
               wr_data = cur_ff;
            end
            rd_addr = addr_type'((pos_ff - cnt_type'(1)) >> 1);
         end
         ST_UP_CMP: begin
            if (cur_ff < rd_data) begin
               wr_en = 1'b1;
               wr_addr = addr_type'(pos_ff);
               wr_data = rd_data;
               pos_in = (pos_ff - cnt_type'(1)) >> 1;
            end else begin
               wr_en = 1'b1;
               wr_addr = addr_type'(pos_ff);
               wr_data = cur_ff;
            end
            rd_addr = addr_type'((((pos_ff - cnt_type'(1)) >> 1) - cnt_type'(1)) >> 1);
         end
         ST_DN_RD: begin
            // first step of a sift may take its value from the store
            if (reload_ff) begin
               cur_in = rd_data;
               best_in = rd_data;
               reload_in = 1'b0;
            end else begin
               best_in = cur_ff;
            end
            rd_addr = addr_type'(lchild);
            bpos_in = pos_ff;
         end
         ST_DN_L: begin
            if (rd_data < best_ff) begin
               best_in = rd_data;
               bpos_in = lchild;
            end
            rd_addr = addr_type'(rchild);
         end
         ST_DN_R: begin
            if (rchild < size_ff && rd_data < best_ff) begin
               best_in = rd_data;
               bpos_in = rchild;
            end
         end
         ST_DN_SWAP: begin
            // nothing to write outside the live heap
            wr_en = (pos_ff < size_ff);
            wr_addr = addr_type'(pos_ff);
            if (bpos_ff != pos_ff) begin
               wr_data = best_ff;
               pos_in = bpos_ff;
            end else begin
               wr_data = cur_ff;
               if (run_sw_ff) begin
                  mv_in = '0;
                  run_sw_in = 1'b0;
               end
            end
            rd_addr = addr_type'(cnt_type'(HeapCap) - parked_ff);
         end
         ST_MV_RD: begin
            rd_addr = addr_type'(cnt_type'(HeapCap) - parked_ff + mv_ff);
         end
         ST_MV_WR: begin
            wr_en = 1'b1;
            wr_addr = addr_type'(mv_ff);
            wr_data = rd_data;
            mv_in = mv_ff + cnt_type'(1);
            if (mv_ff == parked_ff - cnt_type'(1)) begin
               live_in = parked_ff;
               parked_in = '0;
               run_in = run_ff + RunW'(1);
               started_in = 1'b0;
               size_in = parked_ff;
               mv_in = (parked_ff >> 1) + cnt_type'(1);
            end
         end
         ST_BUILD: begin
            mv_in = mv_ff - cnt_type'(1);
            pos_in = mv_ff - cnt_type'(1);
            rd_addr = addr_type'(mv_ff - cnt_type'(1));
            reload_in = 1'b1;
         end
         ST_DONE: begin
         end
         ST_OUT: begin
         end
         default: begin
         end
      endcase
   end
endmodule

### hw/rtl/rsr_ram.sv
// ----------------------------------------------------------------------------
// rsr_ram
// key store: one write port, one registered read port
// ----------------------------------------------------------------------------
module rsr_ram (
   input  logic             clock,
   input  logic             wr_en,
   input  rsr_pkg::addr_type wr_addr,
   input  rsr_pkg::key_type wr_data,
   input  rsr_pkg::addr_type rd_addr,
   output rsr_pkg::key_type rd_data
);
   import rsr_pkg::*;

   key_type mem [HeapCap];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

### hw/rtl/rsr_checker.sv
// ----------------------------------------------------------------------------
// rsr_checker
// port level checks of the run generator
// ----------------------------------------------------------------------------
`include "replacement_selection_runs_defines.svh"
module rsr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_run_first,
   input logic        rsp_empty_res,
   input logic [31:0] rsp_out_key
);
   // no request taken while a result waits
   `RSR_ASSERT_IMP(a_busy_out, clock, reset, rsp_valid, req_stall)
   // an empty result never starts a run
   `RSR_ASSERT_IMP(a_empty_first, clock, reset, rsp_valid && rsp_empty_res, !rsp_run_first)
   // empty result carries a zero key
   `RSR_ASSERT_IMP(a_empty_key, clock, reset, rsp_valid && rsp_empty_res, rsp_out_key == '0)
   // a stalled result stays
   `RSR_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
endmodule

bind replacement_selection_runs rsr_checker u_rsr_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_run_first(rsp_run_first),
   .rsp_empty_res(rsp_empty_res),
   .rsp_out_key  (rsp_out_key)
);

### tb/sv/replacement_selection_runs_tb.sv
// ----------------------------------------------------------------------------
// replacement_selection_runs_tb
// drives push and drain items into the run generator, tracks the heap, the
// parked keys and the run number in a local copy, and checks every rsp item
// field by field against the oldest predicted item
// ----------------------------------------------------------------------------
module replacement_selection_runs_tb;
   import rsr_pkg::*;

   typedef struct {
      key_type     key;
      logic [15:0] run;
      logic        first;
      logic        empty;
   } run_item_type;

   typedef struct {
      logic         cmd;
      key_type      key;
      bit           typed;
      run_item_type want;
   } stim_row_type;

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic           req_valid = 1'b0;
   logic           req_stall;
   logic           req_cmd = CmdPush;
   key_type        req_key = '0;
   logic           rsp_valid;
   logic           rsp_stall = 1'b0;
   key_type        rsp_out_key;
   logic [15:0]    rsp_run_index;
   logic           rsp_run_first;
   logic           rsp_empty_res;

   replacement_selection_runs DUT (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // generous upper bound, run switches heapify up to the whole store
   initial begin
      #8000000;
      $display("Simulation FAILED");
      $finish;
   end

   // local model of the heap store and run bookkeeping
   int          heap_keys [HeapCap];
   int unsigned live_n;
   int unsigned parked_n;
   logic [15:0] run_no;
   bit          run_begun;

   run_item_type pending_items [$];
   int           mismatches = 0;

   function automatic void sift_down(int unsigned pos, int unsigned size);
      int unsigned l, r, m;
      int t;
      while (pos < size) begin
         l = 2 * pos + 1;
         r = l + 1;
         m = pos;
         if (l < size && heap_keys[l] < heap_keys[m]) m = l;
         if (r < size && heap_keys[r] < heap_keys[m]) m = r;
         if (m == pos) break;
         t = heap_keys[pos];
         heap_keys[pos] = heap_keys[m];
         heap_keys[m] = t;
         pos = m;
      end
   endfunction

   function automatic void sift_up(int unsigned pos);
      int unsigned p;
      int t;
      while (pos > 0) begin
         p = (pos - 1) / 2;
         if (!(heap_keys[pos] < heap_keys[p])) break;
         t = heap_keys[pos];
         heap_keys[pos] = heap_keys[p];
         heap_keys[p] = t;
         pos = p;
      end
   endfunction

   // live heap ran dry: parked keys move down and become the next run
   function automatic void start_next_run();
      int unsigned i;
      if (live_n != 0 || parked_n == 0) return;
      for (i = 0; i < parked_n; i++) heap_keys[i] = heap_keys[HeapCap - parked_n + i];
      live_n = parked_n;
      parked_n = 0;
      i = live_n / 2 + 1;
      while (i > 0) begin
         i--;
         sift_down(i, live_n);
      end
      run_no++;
      run_begun = 0;
   endfunction

   function automatic run_item_type emit_root();
      run_item_type e;
      e.key = heap_keys[0];
      e.run = run_no;
      e.first = !run_begun;
      e.empty = 1'b0;
      run_begun = 1;
      return e;
   endfunction

   // returns 1 when the item yields an rsp item
   function automatic bit predict_run_item(logic cmd, key_type k, output run_item_type e);
      e = '{key: '0, run: '0, first: 1'b0, empty: 1'b0};
      if (cmd == CmdPush) begin
         if (live_n + parked_n < HeapCap) begin
            if (run_begun && live_n > 0 && k < heap_keys[0]) begin
               parked_n++;
               heap_keys[HeapCap - parked_n] = k;
            end else begin
               heap_keys[live_n] = k;
               live_n++;
               sift_up(live_n - 1);
            end
            return 0;
         end
         e = emit_root();
         if (k >= heap_keys[0]) begin
            heap_keys[0] = k;
            sift_down(0, live_n);
         end else begin
            heap_keys[0] = heap_keys[live_n - 1];
            live_n--;
            parked_n++;
            heap_keys[HeapCap - parked_n] = k;
            sift_down(0, live_n);
            start_next_run();
         end
         return 1;
      end
      if (live_n == 0) begin
         e.empty = 1'b1;
         return 1;
      end
      e = emit_root();
      heap_keys[0] = heap_keys[live_n - 1];
      live_n--;
      sift_down(0, live_n);
      if (live_n == 0 && parked_n == 0) begin
         run_no++;
         run_begun = 0;
      end else begin
         start_next_run();
      end
      return 1;
   endfunction

   // directed rows; typed expectations only where obvious
   localparam int NDIR = 15;
   stim_row_type dir_rows [NDIR] = '{
      // drain with nothing stored
      '{CmdDrain, 32'sd0, 1, '{'0, '0, 1'b0, 1'b1}},
      '{CmdPush, -32'sd2147483648, 0, '{'0, '0, 1'b0, 1'b0}},
      '{CmdPush, 32'sd2147483647, 0, '{'0, '0, 1'b0, 1'b0}},
      // extremes come back in order in run zero
      '{CmdDrain, 32'sd0, 1, '{-32'sd2147483648, 16'd0, 1'b1, 1'b0}},
      '{CmdDrain, 32'sd0, 1, '{32'sd2147483647, 16'd0, 1'b0, 1'b0}},
      '{CmdDrain, -32'sd1, 1, '{'0, '0, 1'b0, 1'b1}},
      // key below the live minimum after the run started is parked
      '{CmdPush, 32'sd10, 0, '{'0, '0, 1'b0, 1'b0}},
      '{CmdPush, 32'sd20, 0, '{'0, '0, 1'b0, 1'b0}},
      '{CmdDrain, 32'sd0, 0, '{'0, '0, 1'b0, 1'b0}},
      '{CmdPush, 32'sd3, 0, '{'0, '0, 1'b0, 1'b0}},
      '{CmdPush, 32'sd20, 0, '{'0, '0, 1'b0, 1'b0}},
      '{CmdDrain, 32'sd0, 0, '{'0, '0, 1'b0, 1'b0}},
      '{CmdDrain, 32'sd0, 0, '{'0, '0, 1'b0, 1'b0}},
      '{CmdDrain, 32'sd0, 0, '{'0, '0, 1'b0, 1'b0}},
      '{CmdDrain, 32'sd0, 1, '{'0, '0, 1'b0, 1'b1}}
   };

   bit calm_mode = 0;

   // drive one item at the falling edge, hold it until taken
   task automatic send_item(logic cmd, key_type k, bit typed, run_item_type want);
      int gap;
      run_item_type e;
      gap = calm_mode ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_cmd = cmd;
      req_key = k;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      if (predict_run_item(cmd, k, e)) pending_items.push_back(typed ? want : e);
   endtask

   // receiver: random stall before each rsp item, compare on acceptance
   initial begin
      int n;
      run_item_type w;
      @(negedge reset);
      forever begin
         n = calm_mode ? 0 : $urandom_range(0, 19);
         if (n > 0) begin
            @(negedge clock);
            rsp_stall = 1'b1;
            repeat (n - 1) @(negedge clock);
            @(negedge clock);
            rsp_stall = 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         if (pending_items.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected rsp item key=%0d run=%0d", rsp_out_key, rsp_run_index);
         end else begin
            w = pending_items.pop_front();
            if (rsp_out_key !== w.key || rsp_run_index !== w.run ||
                rsp_run_first !== w.first || rsp_empty_res !== w.empty) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch exp key=%0d run=%0d first=%0b empty=%0b got %0d %0d %0b %0b",
                           w.key, w.run, w.first, w.empty, rsp_out_key, rsp_run_index,
                           rsp_run_first, rsp_empty_res);
            end
         end
      end
   end

   initial begin
      int i, mode, down_key, up_key, burst;
      logic cmd;
      key_type k;
      run_item_type none;
      none = '{key: '0, run: '0, first: 1'b0, empty: 1'b0};
      live_n = 0;
      parked_n = 0;
      run_no = '0;
      run_begun = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (i = 0; i < NDIR; i++)
         send_item(dir_rows[i].cmd, dir_rows[i].key, dir_rows[i].typed, dir_rows[i].want);

      // sender holds off until every predicted item has come back
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_items.size() != 0) @(posedge clock);

      mode = 0;
      down_key = 1000000;
      up_key = -1000000;
      burst = 0;
      for (i = 0; i < 1800; i++) begin
         if (i % 64 == 0) mode = $urandom_range(0, 3);
         calm_mode = (i % 300) >= 260;
         // one long drain burst to cross a run switch from drains
         if (i == 1500) burst = 40;
         if (burst > 0) begin
            cmd = CmdDrain;
            burst--;
         end else if (live_n + parked_n < HeapCap) begin
            cmd = ($urandom_range(0, 99) < 3) ? CmdDrain : CmdPush;
         end else begin
            cmd = ($urandom_range(0, 99) < 15) ? CmdDrain : CmdPush;
         end
         case (mode)
            0: k = $urandom;
            1: k = $signed($urandom_range(0, 8)) - 4;
            2: begin
               k = down_key;
               down_key -= $urandom_range(0, 3);
            end
            default: begin
               k = up_key;
               up_key += $urandom_range(0, 3);
            end
         endcase
         send_item(cmd, k, 0, none);
      end
      @(negedge clock);
      req_valid = 1'b0;
      calm_mode = 0;

      while (pending_items.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
